// ===== rtl/utf8v_pkg.sv =====
package utf8v_pkg;

   typedef logic [2:0] fault_kind_type;

   localparam fault_kind_type KIND_NONE       = 3'd0;
   localparam fault_kind_type KIND_MISSING    = 3'd1;
   localparam fault_kind_type KIND_INVALID    = 3'd2;
   localparam fault_kind_type KIND_OVERLONG   = 3'd3;
   localparam fault_kind_type KIND_RESTRICTED = 3'd4;

   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned CP_W     = 21;

   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [CP_W-1:0]     code_point_type;
   typedef logic [2:0]          char_len_type;

   localparam code_point_type SURR_LO  = 21'h00D800;
   localparam code_point_type SURR_HI  = 21'h00DFFF;
   localparam code_point_type MIN_CP_4 = 21'h010000;
   localparam code_point_type MIN_CP_3 = 21'h000800;
   localparam code_point_type MIN_CP_2 = 21'h000080;

   function automatic code_point_type min_code(input char_len_type len);
      code_point_type m;
      case (len)
         3'd4:    m = MIN_CP_4;
         3'd3:    m = MIN_CP_3;
         default: m = MIN_CP_2;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/utf8_stream_validator_core.sv =====
// The verdict of a string appears on the rsp_ port in the cycle after its final
// byte is accepted. Throughput: one byte per cycle; the per-byte decode is a single
// pass of compare logic between the decoder state registers and the result register.
// A final byte waits only while a previous verdict is still held unread.
// Reset (synchronous, active high) clears the decoder state and drops rsp_valid.
module utf8_stream_validator_core #(
   parameter int unsigned MAX_STRING_LEN = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_final_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_invalid_found,
   output utf8v_pkg::fault_kind_type rsp_fault_kind,
   output utf8v_pkg::offset_type     rsp_fault_offset
);
   import utf8v_pkg::*;

   localparam int unsigned POS_LIMIT_I =
      ((MAX_STRING_LEN - 1) < 65535) ? (MAX_STRING_LEN - 1) : 65535;
   localparam offset_type POS_LIMIT = offset_type'(POS_LIMIT_I);

   logic           fault_ff,    fault_in;
   fault_kind_type kind_ff,     kind_in;
   offset_type     foff_ff,     foff_in;
   offset_type     pos_ff,      pos_in;
   offset_type     start_ff,    start_in;
   char_len_type   exp_ff,      exp_in;
   char_len_type   taken_ff,    taken_in;
   code_point_type cp_ff,       cp_in;
   logic           bad_ff,      bad_in;

   logic           rsp_valid_ff,   rsp_valid_in;
   logic           rsp_invalid_ff, rsp_invalid_in;
   fault_kind_type rsp_kind_ff,    rsp_kind_in;
   offset_type     rsp_off_ff,     rsp_off_in;

   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_final_byte;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic           lat;
      fault_kind_type lk;
      offset_type     lo;
      char_len_type   nt;
      lat      = fault_ff;
      lk       = kind_ff;
      lo       = foff_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      exp_in   = exp_ff;
      taken_in = taken_ff;
      cp_in    = cp_ff;
      bad_in   = bad_ff;
      nt       = taken_ff + 3'd1;

      if (!fault_ff) begin
         if (exp_ff == 3'd0) begin
            start_in = pos_ff;
            taken_in = 3'd1;
            bad_in   = 1'b0;
            if (!req_data_byte[7]) begin
               taken_in = 3'd0;
            end else if (req_data_byte[7:5] == 3'b110) begin
               exp_in = 3'd2;
               cp_in  = code_point_type'(req_data_byte[4:0]);
            end else if (req_data_byte[7:4] == 4'b1110) begin
               exp_in = 3'd3;
               cp_in  = code_point_type'(req_data_byte[3:0]);
            end else if (req_data_byte[7:3] == 5'b11110) begin
               if (req_data_byte >= 8'hF5) begin
                  lat      = 1'b1;
                  lk       = KIND_RESTRICTED;
                  lo       = pos_ff;
                  taken_in = 3'd0;
               end else begin
                  exp_in = 3'd4;
                  cp_in  = code_point_type'(req_data_byte[2:0]);
               end
            end else begin
               lat      = 1'b1;
               lk       = KIND_INVALID;
               lo       = pos_ff;
               taken_in = 3'd0;
            end
         end else begin
            if (req_data_byte[7:6] != 2'b10) begin
               bad_in = 1'b1;
            end
            cp_in    = {cp_ff[CP_W-7:0], req_data_byte[5:0]};
            taken_in = nt;
            if (nt >= exp_ff) begin
               if (bad_in) begin
                  lat = 1'b1;
                  lk  = KIND_INVALID;
                  lo  = start_ff;
               end else if (cp_in >= SURR_LO && cp_in <= SURR_HI) begin
                  lat = 1'b1;
                  lk  = KIND_RESTRICTED;
                  lo  = start_ff;
               end else if (cp_in < min_code(exp_ff)) begin
                  lat = 1'b1;
                  lk  = KIND_OVERLONG;
                  lo  = start_ff;
               end
               exp_in   = 3'd0;
               taken_in = 3'd0;
               bad_in   = 1'b0;
            end
         end
         if (req_final_byte && exp_in != 3'd0 && !lat) begin
            lat = 1'b1;
            lk  = KIND_MISSING;
            lo  = start_in;
         end
      end

      if (pos_ff < POS_LIMIT) begin
         pos_in = pos_ff + offset_type'(1);
      end

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_off_in     = rsp_off_ff;
      fault_in       = lat;
      kind_in        = lk;
      foff_in        = lo;

      if (req_final_byte) begin
         rsp_valid_in   = 1'b1;
         rsp_invalid_in = lat;
         rsp_kind_in    = lat ? lk : KIND_NONE;
         rsp_off_in     = lat ? lo : '0;
         fault_in       = 1'b0;
         kind_in        = KIND_NONE;
         foff_in        = '0;
         pos_in         = '0;
         start_in       = '0;
         exp_in         = 3'd0;
         taken_in       = 3'd0;
         cp_in          = '0;
         bad_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff     <= 1'b0;
         kind_ff      <= KIND_NONE;
         foff_ff      <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         exp_ff       <= 3'd0;
         taken_ff     <= 3'd0;
         cp_ff        <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fault_ff <= fault_in;
            kind_ff  <= kind_in;
            foff_ff  <= foff_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            exp_ff   <= exp_in;
            taken_ff <= taken_in;
            cp_ff    <= cp_in;
            bad_ff   <= bad_in;
         end
         if (accept && req_final_byte) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= rsp_valid_ff && !rsp_ready;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_final_byte && rsp_valid_in) begin
         rsp_invalid_ff <= rsp_invalid_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_off_ff     <= rsp_off_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_invalid_found = rsp_invalid_ff;
   assign rsp_fault_kind    = rsp_kind_ff;
   assign rsp_fault_offset  = rsp_off_ff;

endmodule
